FILE: rtl/chx_pkg.sv
// Shared constants, types and helpers for the control character hex escape codec.
package chx_pkg;

  // Width of one character on the ports
  localparam int CHAR_W = 16;
  // Default width that characters are masked to
  localparam int CHAR_BITS = 16;
  // Longest escape sequence and the pending buffer in front of it
  localparam int SEQ_LEN = 5;
  localparam int HOLD_DEPTH = 4;
  localparam int CNT_W = $clog2(SEQ_LEN + 1);
  localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);

  // Characters at and above this code pass through in escape mode
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  // Character codes of the escape sequence and the hex digit ranges
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_X = 8'h78;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  // 'A' - 10, the offset of letter digits
  localparam logic [7:0] HEX_LETTER_BASE = 8'h37;

  // Mode register values
  typedef enum logic {
    DIR_ESCAPE   = 1'b0,
    DIR_UNESCAPE = 1'b1
  } chx_dir_e;

  // Results of one request: up to five characters and their count
  typedef struct packed {
    logic [SEQ_LEN-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]               cnt;
  } chx_res_t;

  // Update of the pending buffer for one request
  typedef struct packed {
    logic                  we;
    logic [HOLD_IDX_W-1:0] idx;
    logic [CNT_W-1:0]      cnt;
  } chx_hold_t;

  // Uppercase hex digit for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + ext;
    end else begin
      hex_char = HEX_LETTER_BASE + ext;
    end
  endfunction

endpackage

FILE: rtl/chx_step.sv
// Combinational step: results and pending buffer update for one request.
module chx_step import chx_pkg::*; #(
  parameter int CharW = CHAR_BITS
) (
  input  logic                                dir_i,
  input  logic [CharW-1:0]                    char_i,
  input  logic                                end_i,
  input  logic [HOLD_DEPTH-1:0][CharW-1:0]    held_i,
  input  logic [CNT_W-1:0]                    held_cnt_i,
  output chx_res_t                            res_o,
  output chx_hold_t                           hold_o
);

  logic             is_hex;
  logic             is_letter;
  logic             pos_ok;
  logic             is_bslash;
  logic [3:0]       hi_nib;
  logic [3:0]       lo_nib;
  logic [3:0]       c_nib;

  // Hex digit class of a character: '0'-'9' or 'A'-'F' only
  function automatic logic hex_ok(input logic [CharW-1:0] ch);
    hex_ok = (ch >= CharW'(CHAR_ZERO) && ch <= CharW'(CHAR_NINE)) ||
             (ch >= CharW'(CHAR_UPPER_A) && ch <= CharW'(CHAR_UPPER_F));
  endfunction

  // Value of a hex digit; letters have low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [CharW-1:0] ch);
    if (ch >= CharW'(CHAR_UPPER_A)) begin
      hex_val = ch[3:0] + 4'd9;
    end else begin
      hex_val = ch[3:0];
    end
  endfunction

  assign is_hex    = hex_ok(char_i);
  assign is_letter = char_i >= CharW'(CHAR_UPPER_A);
  assign is_bslash = char_i == CharW'(CHAR_BSLASH);
  assign hi_nib    = hex_val(held_i[HOLD_DEPTH-1]);
  assign c_nib     = is_letter ? (char_i[3:0] + 4'd9) : char_i[3:0];
  assign lo_nib    = char_i[3:0];

  // Does the new character continue the pending prefix at its position
  always_comb begin
    case (held_cnt_i)
      CNT_W'(0): pos_ok = is_bslash;
      CNT_W'(1): pos_ok = char_i == CharW'(CHAR_ZERO);
      CNT_W'(2): pos_ok = char_i == CharW'(CHAR_X);
      default:   pos_ok = is_hex;
    endcase
  end

  // Result characters and buffer update
  always_comb begin
    // literal flush order: pending characters, then the new one
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      res_o.chars[k] = (CNT_W'(k) < held_cnt_i) ? CHAR_W'(held_i[k]) : CHAR_W'(char_i);
    end
    res_o.chars[SEQ_LEN-1] = CHAR_W'(char_i);
    res_o.cnt  = '0;
    hold_o.we  = 1'b0;
    hold_o.idx = held_cnt_i[HOLD_IDX_W-1:0];
    hold_o.cnt = held_cnt_i;

    if (dir_i == DIR_ESCAPE) begin
      if (char_i < CharW'(CTRL_LIMIT)) begin
        res_o.chars[0] = CHAR_W'(CHAR_BSLASH);
        res_o.chars[1] = CHAR_W'(CHAR_ZERO);
        res_o.chars[2] = CHAR_W'(CHAR_X);
        res_o.chars[3] = CHAR_W'(hex_char(char_i[7:4]));
        res_o.chars[4] = CHAR_W'(hex_char(lo_nib));
        res_o.cnt      = CNT_W'(SEQ_LEN);
      end else begin
        res_o.chars[0] = CHAR_W'(char_i);
        res_o.cnt      = CNT_W'(1);
      end
    end else if (pos_ok && held_cnt_i == CNT_W'(HOLD_DEPTH)) begin
      // complete sequence: one decoded character
      res_o.chars[0] = CHAR_W'({hi_nib, c_nib});
      res_o.cnt      = CNT_W'(1);
      hold_o.cnt     = '0;
    end else if (pos_ok) begin
      if (end_i) begin
        res_o.cnt  = held_cnt_i + CNT_W'(1);
        hold_o.cnt = '0;
      end else begin
        hold_o.we  = 1'b1;
        hold_o.cnt = held_cnt_i + CNT_W'(1);
      end
    end else if (is_bslash && !end_i) begin
      // mismatch; the backslash opens a new prefix
      res_o.cnt  = held_cnt_i;
      hold_o.we  = 1'b1;
      hold_o.idx = '0;
      hold_o.cnt = CNT_W'(1);
    end else begin
      res_o.cnt  = held_cnt_i + CNT_W'(1);
      hold_o.cnt = '0;
    end
  end

endmodule

FILE: rtl/chx_outbuf.sv
// Result register: holds the results of one request and hands them out one per cycle unless stalled.
module chx_outbuf import chx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  chx_res_t           res_i,
  input  logic               last_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  char_out_o,
  output logic               last_out_o
);

  logic [SEQ_LEN-1:0][CHAR_W-1:0] buf_q;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [CNT_W-1:0]               idx_q, idx_d;
  logic                           last_q;
  logic                           at_end;
  logic                           take;

  assign at_end      = idx_q == cnt_q - CNT_W'(1);
  assign out_valid_o = cnt_q != '0;
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = !out_valid_o || (take && at_end);
  assign char_out_o  = buf_q[idx_q];
  assign last_out_o  = last_q && at_end;

  // Read pointer and fill count
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = res_i.cnt;
      idx_d = '0;
    end else if (take) begin
      if (at_end) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q  <= res_i.chars;
      last_q <= last_i;
    end
  end

endmodule

FILE: rtl/control_char_hex_escape_codec.sv
// Control character hex escape codec: one request per cycle while not stalled, up to
// five results each, backslash-0x-hex-hex sequences either made from or decoded back
// into characters. A request that gives one result (or none) does not hold off the
// next one, so plain text passes at one character per clock while the output does not
// stall. A request with several results, an escaped control character or a literal
// flush, holds off the next one until its results have left, since the result register
// hands out one character per cycle while not stalled. Requests pass the input
// register, then the result register. A mode write drops any pending partial sequence.
module control_char_hex_escape_codec import chx_pkg::*; #(
  parameter int CharBits = CHAR_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CHAR_W-1:0]  char_in_i,
  input  logic               end_of_text_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  char_out_o,
  output logic               last_out_o
);

  // Characters are masked to CharBits; the ports carry no more than CHAR_W bits
  localparam int CharW = (CharBits < CHAR_W) ? CharBits : CHAR_W;

  logic                             dir_q;
  logic                             in_v_q;
  logic [CharW-1:0]                 in_char_q;
  logic                             in_end_q;
  logic [HOLD_DEPTH-1:0][CharW-1:0] held_q;
  logic [CNT_W-1:0]                 held_cnt_q;
  logic                             accept;
  logic                             move;
  logic                             ob_free;
  chx_res_t                         res;
  chx_hold_t                        hold;

  assign move       = in_v_q && ob_free;
  assign in_stall_o = in_v_q && !ob_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register control and mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      dir_q      <= DIR_ESCAPE;
      held_cnt_q <= '0;
    end else begin
      if (accept) begin
        in_v_q <= 1'b1;
      end else if (move) begin
        in_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        dir_q      <= cfg_wdata_i;
        held_cnt_q <= '0;
      end else if (move) begin
        held_cnt_q <= hold.cnt;
      end
    end
  end

  // Input payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_char_q <= char_in_i[CharW-1:0];
      in_end_q  <= end_of_text_i;
    end
  end

  // Pending partial sequence
  always_ff @(posedge clk_i) begin
    if (move && hold.we) begin
      held_q[hold.idx] <= in_char_q;
    end
  end

  chx_step #(
    .CharW (CharW)
  ) u_step (
    .dir_i      (dir_q),
    .char_i     (in_char_q),
    .end_i      (in_end_q),
    .held_i     (held_q),
    .held_cnt_i (held_cnt_q),
    .res_o      (res),
    .hold_o     (hold)
  );

  chx_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (move),
    .res_i       (res),
    .last_i      (in_end_q),
    .free_o      (ob_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_out_o  (last_out_o)
  );

endmodule

FILE: tb/chx_stream_check.sv
// Stream checker for the hex escape codec: predicts results per request and compares them.
`timescale 1ns / 100ps

module chx_stream_check import chx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [CHAR_W-1:0] char_in_i,
  input  logic              end_of_text_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [CHAR_W-1:0] char_out_i,
  input  logic              last_out_i,
  output int                fail_cnt_o,
  output int                pending_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  localparam logic [CHAR_W-1:0] ASC_BSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] ASC_ZERO   = 16'h0030;
  localparam logic [CHAR_W-1:0] ASC_X      = 16'h0078;
  localparam logic [CHAR_W-1:0] CTRL_TOP   = 16'd32;

  // Shadow of the block: mode register and the partial sequence
  chx_dir_e          mode;
  logic [CHAR_W-1:0] held [HOLD_DEPTH];
  int                held_cnt;
  text_char_t        result_q[$];
  int                fails;

  // Value of an uppercase hex digit, -1 for anything else
  function automatic int hex_val(input logic [CHAR_W-1:0] c);
    if (c >= 16'h0030 && c <= 16'h0039) begin
      return int'(c) - 'h30;
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      return int'(c) - 'h37;
    end
    return -1;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ASC_ZERO + CHAR_W'(nib);
    end
    return 16'h0041 + CHAR_W'(nib) - 16'd10;
  endfunction

  // True when the first len characters can open a backslash-0-x-hex-hex sequence
  function automatic logic prefix_ok(input logic [SEQ_LEN-1:0][CHAR_W-1:0] b, input int len);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < len; k++) begin
      case (k)
        0:       ok = ok && (b[k] == ASC_BSLASH);
        1:       ok = ok && (b[k] == ASC_ZERO);
        2:       ok = ok && (b[k] == ASC_X);
        default: ok = ok && (hex_val(b[k]) >= 0);
      endcase
    end
    return ok;
  endfunction

  // Work out the results of one request and queue them
  task automatic predict_results(input logic [CHAR_W-1:0] c, input logic eot);
    logic [SEQ_LEN-1:0][CHAR_W-1:0] scan;
    logic [SEQ_LEN-1:0][CHAR_W-1:0] outs;
    text_char_t item;
    logic matched;
    int len, n, hi, lo;
    n = 0;
    len = 0;
    scan = '0;
    outs = '0;
    if (mode == DIR_ESCAPE) begin
      if (c < CTRL_TOP) begin
        outs[0] = ASC_BSLASH;
        outs[1] = ASC_ZERO;
        outs[2] = ASC_X;
        outs[3] = digit_char(c[7:4]);
        outs[4] = digit_char(c[3:0]);
        n = 5;
      end else begin
        outs[0] = c;
        n = 1;
      end
    end else begin
      for (int k = 0; k < held_cnt; k++) scan[k] = held[k];
      scan[held_cnt] = c;
      len = held_cnt + 1;
      matched = 1'b0;
      // Drop leading characters literally until the rest is a live prefix
      while (len > 0 && !matched) begin
        if (prefix_ok(scan, len)) begin
          matched = 1'b1;
          if (len == SEQ_LEN) begin
            hi = hex_val(scan[3]);
            lo = hex_val(scan[4]);
            outs[n] = CHAR_W'(hi * 16 + lo);
            n++;
            len = 0;
          end
        end else begin
          outs[n] = scan[0];
          n++;
          for (int k = 0; k < SEQ_LEN - 1; k++) scan[k] = scan[k+1];
          len--;
        end
      end
      // End of text flushes whatever is still pending
      if (eot) begin
        for (int k = 0; k < len; k++) begin
          outs[n] = scan[k];
          n++;
        end
        len = 0;
      end
      for (int k = 0; k < len; k++) held[k] = scan[k];
      held_cnt = len;
    end
    for (int k = 0; k < n; k++) begin
      item.ch = outs[k];
      item.last = eot && (k == n - 1);
      result_q.push_back(item);
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      mode = DIR_ESCAPE;
      held_cnt = 0;
      fails = 0;
      result_q.delete();
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        mode = chx_dir_e'(cfg_wdata_i);
        held_cnt = 0;
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: char_out=%h last_out=%b", char_out_i, last_out_i);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (char_out_i !== want.ch) begin
            $error("char_out: expected %h, got %h", want.ch, char_out_i);
            fails++;
          end
          if (last_out_i !== want.last) begin
            $error("last_out: expected %b, got %b", want.last, last_out_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_results(char_in_i, end_of_text_i);
      fail_cnt_o <= fails;
      pending_o <= result_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the codec testbench: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps

module testbench;
  import chx_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;

  localparam logic [CHAR_W-1:0] ASC_BSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] ASC_ZERO   = 16'h0030;
  localparam logic [CHAR_W-1:0] ASC_X      = 16'h0078;
  localparam logic [CHAR_W-1:0] ASC_UP_F   = 16'h0046;
  localparam logic [CHAR_W-1:0] ASC_LOW_A  = 16'h0061;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pat_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] char_in = '0;
  logic              end_of_text = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] char_out;
  logic              last_out;
  int                fail_cnt;
  int                pending;

  int         burst_left = 0;
  int         stall_left = 0;
  int         stall_tick = 0;
  stall_pat_e stall_pat = STALL_NONE;
  int         cycle_cnt = 0;

  always #5 clk = ~clk;

  control_char_hex_escape_codec dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .char_in_i     (char_in),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .char_out_o    (char_out),
    .last_out_o    (last_out)
  );

  chx_stream_check stream_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .char_in_i     (char_in),
    .end_of_text_i (end_of_text),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .char_out_i    (char_out),
    .last_out_i    (last_out),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  // Receiver stall: patterns of random length, one of them never stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pat = stall_pat_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_pat)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_tick % 5) < 2);
    endcase
  end

  // Hand one request to the block; the sender runs in bursts with gaps between
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    char_in <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Hold off the sender until every predicted result has left the block
  task automatic wait_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mode changes only once the block has gone quiet
  task automatic set_mode(input chx_dir_e d);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] hex_pick();
    if ($urandom_range(0, 1) == 0) begin
      return CHAR_W'($urandom_range(16'h0030, 16'h0039));
    end
    return CHAR_W'($urandom_range(16'h0041, 16'h0046));
  endfunction

  // Characters that sit close to the sequence syntax, plus wide and random noise
  function automatic logic [CHAR_W-1:0] stray_char();
    logic [CHAR_W-1:0] near;
    case ($urandom_range(0, 12))
      0:       near = ASC_BSLASH;
      1:       near = ASC_ZERO;
      2:       near = ASC_X;
      3:       near = 16'h0058;
      4:       near = ASC_LOW_A;
      5:       near = 16'h0066;
      6:       near = 16'h0047;
      7:       near = 16'h002F;
      8:       near = 16'h003A;
      9:       near = 16'h0040;
      10:      near = 16'h0039;
      11:      near = 16'h0041;
      default: near = ASC_UP_F;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2:    return CHAR_W'($urandom);
      3, 4, 5, 6: return near;
      7:          return {8'($urandom_range(1, 255)), near[7:0]};
      default:    return CHAR_W'($urandom_range(16'h0020, 16'h007E));
    endcase
  endfunction

  // Escape mode traffic: heavy on control characters
  task automatic random_escape(input int count);
    logic [CHAR_W-1:0] c;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        c = CHAR_W'($urandom_range(0, 31));
      end else if (r < 7) begin
        c = CHAR_W'($urandom);
      end else begin
        c = CHAR_W'($urandom_range(32, 126));
      end
      send_char(c, $urandom_range(0, 11) == 0);
    end
  endtask

  // Unescape traffic: mostly whole sequences, some cut short, some noise
  task automatic random_unescape(input int count);
    logic [SEQ_LEN:0][CHAR_W-1:0] seq;
    int sent, kind, len, eot_at;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      seq = '0;
      seq[0] = ASC_BSLASH;
      seq[1] = ASC_ZERO;
      seq[2] = ASC_X;
      seq[3] = hex_pick();
      seq[4] = hex_pick();
      eot_at = -1;
      if (kind < 5) begin
        len = SEQ_LEN;
        if ($urandom_range(0, 5) == 0) eot_at = SEQ_LEN - 1;
      end else if (kind < 8) begin
        len = $urandom_range(1, 4);
        seq[len] = stray_char();
        len++;
        if ($urandom_range(0, 4) == 0) eot_at = $urandom_range(0, len - 1);
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) seq[k] = stray_char();
        if ($urandom_range(0, 9) == 0) eot_at = len - 1;
      end
      for (int k = 0; k < len; k++) send_char(seq[k], k == eot_at);
      sent += len;
    end
  endtask

  // Run-away guard
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("control_char_hex_escape_codec: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Escape mode out of reset: control range edges, wide and plain characters
    send_char(16'h0000, 1'b0);
    send_char(16'h001F, 1'b0);
    send_char(16'h0020, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h007F, 1'b0);
    send_char(16'h000A, 1'b1);

    // Unescape: a doubled backslash, then a full sequence ending the text
    set_mode(DIR_UNESCAPE);
    send_char(ASC_BSLASH, 1'b0);
    send_char(ASC_BSLASH, 1'b0);
    send_char(ASC_ZERO, 1'b0);
    send_char(ASC_X, 1'b0);
    send_char(ASC_UP_F, 1'b0);
    send_char(ASC_UP_F, 1'b1);
    // lowercase letter is not a hex digit
    send_char(ASC_BSLASH, 1'b0);
    send_char(ASC_ZERO, 1'b0);
    send_char(ASC_X, 1'b0);
    send_char(ASC_LOW_A, 1'b0);
    // end of text in the middle of a prefix flushes it
    send_char(ASC_BSLASH, 1'b0);
    send_char(ASC_ZERO, 1'b1);
    // prefix left pending, then dropped by the mode write
    send_char(ASC_BSLASH, 1'b0);
    send_char(ASC_ZERO, 1'b0);
    send_char(ASC_X, 1'b0);
    send_char(ASC_ZERO, 1'b0);
    set_mode(DIR_UNESCAPE);

    // Random phases in both modes
    for (int p = 0; p < 6; p++) begin
      if (p % 3 == 0) begin
        set_mode(DIR_ESCAPE);
        random_escape(78);
      end else begin
        set_mode(DIR_UNESCAPE);
        random_unescape(39);
        if (p == 2) wait_results();
        random_unescape(39);
      end
    end

    wait_results();
    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("control_char_hex_escape_codec: match");
    end else begin
      $display("control_char_hex_escape_codec: mismatch");
    end
    $finish;
  end

endmodule
